// ===== rtl/core/mexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  // Field positions in the input tdata word.
  localparam int BASE_LSB = 0;
  localparam int BASE_W   = 32;
  localparam int EXP_LSB  = 32;
  localparam int MOD_LSB  = 95;
  localparam int IN_W     = 128;
  localparam int OUT_W    = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_BASE_RED,
    ST_BIT,
    ST_MUL,
    ST_REDUCE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;          // capture a new operand set, acc <= 1
    logic clr_acc;       // acc <= 0
    logic rem_start;     // start the remainder unit
    logic rem_src_base;  // dividend is the base rather than the product
    logic mul_go;        // product <= operands
    logic mul_sq;        // operands are pw * pw rather than acc * pw
    logic wr_acc;        // acc <= remainder
    logic wr_pw;         // pw <= remainder
    logic shift_exp;     // exponent >>= 1
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_bit0;
    logic exp_last;
    logic mod_zero;
    logic rem_done;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mexp_rem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, two dividend bits per cycle, MSB first.
module mexp_rem #(
  parameter int MW = 31,
  parameter int DW = 62
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [MW-1:0] modulus,
  output logic      [MW-1:0] remainder,
  output logic               done
);

  localparam int STEPS = DW / 2;
  localparam int CW    = $clog2(STEPS);

  logic [DW-1:0] div_r, div_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  function automatic logic [MW-1:0] rstep(input logic [MW-1:0] r, input logic b,
                                          input logic [MW-1:0] m);
    logic [MW:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[MW-1:0];
  endfunction

  always_comb begin
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      div_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = rstep(rstep(rem_r, div_r[DW-1], modulus), div_r[DW-2], modulus);
      div_nxt = {div_r[DW-3:0], 2'b00};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign remainder = rem_r;
  assign done      = done_r;

endmodule

`default_nettype wire

// ===== rtl/core/mexp_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mexp_dp #(
  parameter int EW = 63,
  parameter int MW = 31,
  parameter int DW = 62
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mexp_pkg::cmd_t          cmd,
  input  wire logic [31:0]             base_in,
  input  wire logic [EW-1:0]           exp_in,
  input  wire logic [MW-1:0]           mod_in,
  output mexp_pkg::status_t            status,
  output logic      [MW-1:0]           result
);
  import mexp_pkg::*;

  logic [31:0]     b_r;
  logic [EW-1:0]   e_r;
  logic [MW-1:0]   m_r;
  logic [MW-1:0]   acc_r;
  logic [MW-1:0]   pw_r;
  logic [2*MW-1:0] prod_r;
  logic [MW-1:0]   mul_a;
  logic [DW-1:0]   rem_dividend;
  logic [MW-1:0]   rem_value;
  logic            rem_done;

  assign mul_a        = cmd.mul_sq ? pw_r : acc_r;
  assign rem_dividend = cmd.rem_src_base ? DW'(b_r) : DW'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_r   <= base_in;
      e_r   <= exp_in;
      m_r   <= mod_in;
      acc_r <= MW'(1);
    end else begin
      if (cmd.clr_acc) begin
        acc_r <= '0;
      end else if (cmd.wr_acc) begin
        acc_r <= rem_value;
      end
      if (cmd.wr_pw) begin
        pw_r <= rem_value;
      end
      if (cmd.shift_exp) begin
        e_r <= e_r >> 1;
      end
    end
    if (cmd.mul_go) begin
      prod_r <= (2*MW)'(mul_a) * (2*MW)'(pw_r);
    end
  end

  mexp_rem #(
    .MW (MW),
    .DW (DW)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.rem_start),
    .dividend  (rem_dividend),
    .modulus   (m_r),
    .remainder (rem_value),
    .done      (rem_done)
  );

  always_comb begin
    status.exp_zero = (e_r == '0);
    status.exp_bit0 = e_r[0];
    status.exp_last = (e_r[EW-1:1] == '0);
    status.mod_zero = (m_r == '0);
    status.rem_done = rem_done;
  end

  assign result = acc_r;

endmodule

`default_nettype wire

// ===== rtl/core/mexp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_free,
  input  wire mexp_pkg::status_t status,
  output logic                   in_ready,
  output logic                   out_load,
  output mexp_pkg::cmd_t         cmd
);
  import mexp_pkg::*;

  state_t state_r, state_nxt;
  logic   tgt_acc_r, tgt_acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      tgt_acc_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tgt_acc_r <= tgt_acc_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    tgt_acc_nxt = tgt_acc_r;
    cmd         = '0;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // No transfer is taken while reset is held.
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (status.exp_zero) begin
          state_nxt = ST_DONE;
        end else if (status.mod_zero) begin
          cmd.clr_acc = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.rem_start    = 1'b1;
          cmd.rem_src_base = 1'b1;
          state_nxt        = ST_BASE_RED;
        end
      end
      ST_BASE_RED: begin
        if (status.rem_done) begin
          cmd.wr_pw = 1'b1;
          state_nxt = ST_BIT;
        end
      end
      ST_BIT: begin
        // Bits above the last set one change nothing, so the scan ends early.
        if (status.exp_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sq  = !status.exp_bit0;
          tgt_acc_nxt = status.exp_bit0;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.rem_start = 1'b1;
        state_nxt     = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (status.rem_done) begin
          if (tgt_acc_r) begin
            cmd.wr_acc = 1'b1;
            if (status.exp_last) begin
              state_nxt = ST_DONE;
            end else begin
              cmd.mul_go  = 1'b1;
              cmd.mul_sq  = 1'b1;
              tgt_acc_nxt = 1'b0;
              state_nxt   = ST_MUL;
            end
          end else begin
            cmd.wr_pw     = 1'b1;
            cmd.shift_exp = 1'b1;
            state_nxt     = ST_BIT;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/modular_exponentiation_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One operand set is in flight at a time. A zero exponent or modulus goes straight to the output
// load; else the base is reduced, each clear exponent bit takes one reduction, each set bit below
// the highest set one takes two, and the highest set one takes one. Each reduction runs in the
// serial remainder unit (two bits per cycle) over DW = max(2*MOD_WIDTH, 32) dividend bits. The
// next transfer is taken after the result is loaded.
// Reset (synchronous, active low) returns the controller to idle and empties the output.
module modular_exponentiation_unit #(
  parameter int EXP_WIDTH = 63,
  parameter int MOD_WIDTH = 31
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // base_value[31:0], exponent_value[94:32], modulus_value[125:95], zero fill
  input  wire logic [mexp_pkg::IN_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // power_residue[30:0], zero fill
  output logic      [mexp_pkg::OUT_W-1:0]  out_tdata
);
  import mexp_pkg::*;

  localparam int DW = (2 * MOD_WIDTH > 32) ? 2 * MOD_WIDTH : 32;

  cmd_t                 cmd;
  status_t              status;
  logic                 out_load;
  logic                 out_free;
  logic [MOD_WIDTH-1:0] result;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r;

  assign out_free = !out_valid_r || out_tready;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_tready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  mexp_dp #(
    .EW (EXP_WIDTH),
    .MW (MOD_WIDTH),
    .DW (DW)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .base_in (in_tdata[BASE_LSB +: BASE_W]),
    .exp_in  (in_tdata[EXP_LSB +: EXP_WIDTH]),
    .mod_in  (in_tdata[MOD_LSB +: MOD_WIDTH]),
    .status  (status),
    .result  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_W'(result);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== verif/modular_exponentiation_unit_tb.sv =====
`timescale 1ns / 1ps

module modular_exponentiation_unit_tb;
  import mexp_pkg::*;

  localparam int EXP_W       = 63;
  localparam int MOD_W       = 31;
  localparam int RES_W       = 31;
  localparam int IDLE_PCT    = 28;
  localparam int HOLD_CYCLES = 1500;
  localparam int QUIET_LIMIT = 40000;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    bit [31:0]      base;
    bit [EXP_W-1:0] exponent;
    bit [MOD_W-1:0] modulus;
    bit [RES_W-1:0] residue;
  } power_job_t;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  bit         steady           = 1'b0;
  bit         hold_ask         = 1'b0;
  int         hold_left        = 0;
  int         quiet_cycles     = 0;
  int         fail_count       = 0;
  int         jobs_accepted    = 0;
  int         residues_checked = 0;
  power_job_t pending_q[$];

  modular_exponentiation_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  // Right-to-left square-and-multiply on 64-bit words; the base is reduced first, so
  // every product of two residues stays below 2^62.
  function automatic bit [RES_W-1:0] predict_power(input bit [31:0] base,
                                                   input bit [EXP_W-1:0] exponent,
                                                   input bit [MOD_W-1:0] modulus);
    bit [63:0] acc;
    bit [63:0] pw;
    bit [63:0] m;
    if (exponent == '0) return RES_W'(1);
    if (modulus == '0) return '0;
    m = 64'(modulus);
    acc = 64'd1;
    pw = 64'(base) % m;
    for (int k = 0; k < EXP_W; k++) begin
      if (exponent[k]) acc = (acc * pw) % m;
      pw = (pw * pw) % m;
    end
    return acc[RES_W-1:0];
  endfunction

  function automatic bit [EXP_W-1:0] pick_exponent(input int lo_len, input int hi_len);
    bit [63:0] raw;
    int len;
    raw = {$urandom, $urandom};
    len = $urandom_range(hi_len, lo_len);
    if (len == 0) return '0;
    raw &= (64'd1 << len) - 64'd1;
    raw[len-1] = 1'b1;
    return raw[EXP_W-1:0];
  endfunction

  function automatic bit [MOD_W-1:0] pick_modulus();
    bit [MOD_W-1:0] m;
    case ($urandom_range(9))
      0: m = MOD_W'(1) << $urandom_range(MOD_W - 1);
      1, 2: m = MOD_W'($urandom_range(255, 2));
      default: m = MOD_W'($urandom);
    endcase
    if (m == '0) m = MOD_W'(1);
    return m;
  endfunction

  function automatic bit [31:0] pick_base(input bit [MOD_W-1:0] modulus);
    case ($urandom_range(9))
      0: return 32'(modulus) * 32'($urandom_range(3));
      1: return 32'($urandom_range(3));
      2: return 32'(modulus) - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one operand set and returns once the transfer has taken place.
  task automatic send_power(input bit [31:0] base, input bit [EXP_W-1:0] exponent,
                            input bit [MOD_W-1:0] modulus);
    logic [IN_W-1:0] word;
    word = '0;
    word[BASE_LSB +: BASE_W] = base;
    word[EXP_LSB +: EXP_W] = exponent;
    word[MOD_LSB +: MOD_W] = modulus;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= word;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_power();
    bit [MOD_W-1:0] modulus;
    bit [EXP_W-1:0] exponent;
    int roll;
    modulus = pick_modulus();
    roll = $urandom_range(99);
    if (roll < 10) exponent = pick_exponent(EXP_W, EXP_W);
    else if (roll < 40) exponent = pick_exponent(0, 8);
    else exponent = pick_exponent(0, EXP_W);
    send_power(pick_base(modulus), exponent, modulus);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    bit [EXP_W-1:0] all_exp;
    bit [MOD_W-1:0] all_mod;
    all_exp = '1;
    all_mod = '1;
    steady = 1'b0;
    // A zero exponent gives one, even with a modulus of one or zero.
    send_power(32'd0, '0, 31'd1);
    send_power(32'hFFFF_FFFF, '0, all_mod);
    send_power(32'd5, '0, 31'd0);
    // A zero modulus with a nonzero exponent cannot reduce and gives zero.
    send_power(32'd5, 63'd3, 31'd0);
    send_power(32'hFFFF_FFFF, all_exp, 31'd1);
    send_power(32'd0, 63'd7, 31'd13);
    send_power(32'd7, 63'd1, 31'd5);
    send_power(32'hFFFF_FFFF, all_exp, all_mod);
    send_power(32'hFFFF_FFFF, 63'd1, all_mod);
    send_power(32'd2, 63'h4000_0000_0000_0000, all_mod);
    send_power(32'd3, all_exp, 31'd2);
    send_power(32'd1, all_exp, all_mod);
    send_power(32'h7FFF_FFFE, 63'd2, all_mod);
    send_power(32'h7FFF_FFFE, 63'd3, all_mod);
    send_power(32'hFFFF_FFFE, 63'd5, all_mod);
    send_power(32'h8000_0000, 63'h5555_5555_5555_5555, 31'h4000_0000);
    send_power(32'h1234_5678, 63'h2AAA_AAAA_AAAA_AAAA, 31'h7FFF_FFED);
    send_power(32'd2, 63'd30, all_mod);
    send_power(32'd2, 63'd31, all_mod);
    wait_drained();
  endtask

  task automatic test_steady_random(input int count);
    steady = 1'b1;
    repeat (count) send_random_power();
    wait_drained();
  endtask

  // The receiver holds off while short jobs keep coming, so the finished result
  // backs up and the input side has to stall.
  task automatic test_output_backpressure();
    bit [MOD_W-1:0] modulus;
    steady = 1'b1;
    @(posedge clk);
    hold_ask <= 1'b1;
    repeat (6) begin
      modulus = pick_modulus();
      send_power($urandom, pick_exponent(1, 6), modulus);
    end
    wait_drained();
  endtask

  task automatic test_mixed_random(input int count);
    steady = 1'b0;
    repeat (count) send_random_power();
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_ask) begin
      hold_ask <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : track_jobs
    power_job_t job;
    power_job_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        job.base = in_tdata[BASE_LSB +: BASE_W];
        job.exponent = in_tdata[EXP_LSB +: EXP_W];
        job.modulus = in_tdata[MOD_LSB +: MOD_W];
        job.residue = predict_power(job.base, job.exponent, job.modulus);
        pending_q.push_back(job);
        jobs_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (pending_q.size() == 0) begin
          $error("power_residue: expected none, actual %0d", out_tdata[RES_W-1:0]);
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          residues_checked++;
          if (out_tdata[RES_W-1:0] !== want.residue) begin
            $error("power_residue: expected %0d, actual %0d (base %0d, exp %0h, mod %0d)",
                   want.residue, out_tdata[RES_W-1:0], want.base, want.exponent,
                   want.modulus);
            fail_count++;
          end
          if (out_tdata[OUT_W-1:RES_W] !== '0) begin
            $error("out_tdata fill: expected 0, actual %0h", out_tdata[OUT_W-1:RES_W]);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_steady_random(40);
    test_output_backpressure();
    test_mixed_random(225);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d exponentiations: zero exponent, zero and unit modulus,",
             residues_checked, jobs_accepted);
    $display("full-width operands and random ones, with random gaps and a long output stall.");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
